FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define GSP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define GSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/gsp_pkg.sv
package gsp_pkg;

  localparam int SLOTS    = 8;
  localparam int TAG_BITS = 16;

  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BUSY_W     = $clog2(SLOTS + 1);
  localparam int CMP_W      = (TAG_BITS > 16) ? TAG_BITS : 16;

  localparam logic [7:0] SLOTS_LIMIT = 8'(SLOTS);

  typedef enum logic [1:0] {
    OP_ACQUIRE  = 2'd0,
    OP_VALIDATE = 2'd1,
    OP_RELEASE  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_INVALID       = 3'd1,
    ST_NOT_ALLOCATED = 3'd2,
    ST_STALE         = 3'd3,
    ST_NO_BUFFERS    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  handle_slot;
    logic [15:0] handle_generation;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot_out;
    logic [15:0] generation_out;
    logic [3:0]  busy_count;
  } out_word_t;

endpackage

FILE: rtl/core/gsp_in_stage.sv
module gsp_in_stage
  import gsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     advance,
  output logic     stage_valid,
  output in_word_t stage_word
);

  logic     stage_valid_r;
  logic     stage_valid_nxt;
  in_word_t stage_word_r;
  logic     load;

  assign in_stall = stage_valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (load) begin
      stage_valid_nxt = 1'b1;
    end else if (advance) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_word_r <= in_word;
    end
  end

  assign stage_valid = stage_valid_r;
  assign stage_word  = stage_word_r;

endmodule

FILE: rtl/core/gsp_alloc.sv
module gsp_alloc
  import gsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  stage_word,
  input  logic      advance,
  output out_word_t result
);

  logic                  slot_busy_r [SLOTS];
  logic [TAG_BITS-1:0]   slot_tag_r  [SLOTS];
  logic [TAG_BITS-1:0]   tag_counter_r;
  logic [TAG_BITS-1:0]   tag_counter_nxt;
  logic [BUSY_W-1:0]     busy_total_r;
  logic [BUSY_W-1:0]     busy_total_nxt;

  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [SLOT_IDX_W-1:0] hidx;
  logic [TAG_BITS-1:0]   tag_inc;
  logic [TAG_BITS-1:0]   tag_new;
  status_t               chk_status;
  status_t               status;
  logic                  grant;
  logic                  free_en;
  logic [7:0]            slot_res;
  logic [15:0]           gen_res;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign hidx    = stage_word.handle_slot[SLOT_IDX_W-1:0];
  assign tag_inc = tag_counter_r + TAG_BITS'(1);
  assign tag_new = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;

  always_comb begin
    if (stage_word.handle_slot >= SLOTS_LIMIT || stage_word.handle_generation == 16'd0) begin
      chk_status = ST_INVALID;
    end else if (!slot_busy_r[hidx]) begin
      chk_status = ST_NOT_ALLOCATED;
    end else if (CMP_W'(slot_tag_r[hidx]) != CMP_W'(stage_word.handle_generation)) begin
      chk_status = ST_STALE;
    end else begin
      chk_status = ST_OK;
    end
  end

  always_comb begin
    status   = ST_INVALID;
    grant    = 1'b0;
    free_en  = 1'b0;
    slot_res = stage_word.handle_slot;
    gen_res  = stage_word.handle_generation;
    unique case (op_t'(stage_word.opcode))
      OP_ACQUIRE: begin
        if (free_found) begin
          status   = ST_OK;
          grant    = 1'b1;
          slot_res = 8'(free_idx);
          gen_res  = 16'(tag_new);
        end else begin
          status   = ST_NO_BUFFERS;
          slot_res = 8'd0;
          gen_res  = 16'd0;
        end
      end
      OP_VALIDATE: begin
        status = chk_status;
      end
      OP_RELEASE: begin
        status  = chk_status;
        free_en = (chk_status == ST_OK);
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    busy_total_nxt  = busy_total_r;
    tag_counter_nxt = tag_counter_r;
    if (grant) begin
      busy_total_nxt  = busy_total_r + BUSY_W'(1);
      tag_counter_nxt = tag_new;
    end else if (free_en) begin
      busy_total_nxt = busy_total_r - BUSY_W'(1);
    end
  end

  assign result.status         = status;
  assign result.slot_out       = slot_res;
  assign result.generation_out = gen_res;
  assign result.busy_count     = 4'(busy_total_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_counter_r <= '0;
      busy_total_r  <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy_r[i] <= 1'b0;
        slot_tag_r[i]  <= '0;
      end
    end else if (advance) begin
      tag_counter_r <= tag_counter_nxt;
      busy_total_r  <= busy_total_nxt;
      if (grant) begin
        slot_busy_r[free_idx] <= 1'b1;
        slot_tag_r[free_idx]  <= tag_new;
      end else if (free_en) begin
        slot_busy_r[hidx] <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/generational_slot_pool.sv
// Generational slot pool: hands out slot handles tagged with a generation.
// Input channel: in_valid / in_stall / in_word (opcode, handle_slot,
// handle_generation). Opcodes: acquire, validate, release.
// Result channel: out_valid / out_stall / out_word (status, slot_out,
// generation_out, busy_count); exactly one result word per input word.
// The word lands in the input register when it is accepted; lookup and
// update fill the result register when the word advances, which waits
// while a held result is stalled.
// Throughput: one word per cycle while out_stall is low; the first-free
// priority encoder and slot-table handle check are both combinational.
// A stalled result holds; the input register still takes one word while the
// held result waits, then in_stall rises until out_stall drops.
// Reset (rst_n low, synchronous): all slots free, generation counter and
// busy count zero, both registers empty. Ready for input as soon as reset
// is released.
module generational_slot_pool
  import gsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      stage_valid;
  in_word_t  stage_word;
  logic      advance;
  out_word_t result;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;

  assign advance = stage_valid && (!out_valid_r || !out_stall);

  gsp_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_word  (stage_word)
  );

  gsp_alloc u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_word (stage_word),
    .advance    (advance),
    .result     (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/core/gsp_checker.sv
`include "assert_macros.svh"

module gsp_checker
  import gsp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  logic is_nobuf;
  logic nobuf_fields_ok;
  logic is_ok;
  logic ok_gen_good;

  assign is_nobuf        = out_valid && out_word.status == ST_NO_BUFFERS;
  assign nobuf_fields_ok = out_word.slot_out == 8'd0 && out_word.generation_out == 16'd0 &&
                           out_word.busy_count == 4'(SLOTS);
  assign is_ok           = out_valid && out_word.status == ST_OK;
  assign ok_gen_good     = (TAG_BITS > 16) || out_word.generation_out != 16'd0;

  `GSP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall, "busy after reset")

  `GSP_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_word), "stalled input word changed")

  `GSP_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled result word changed")

  `GSP_ASSERT(a_no_buf_full, clk, rst_n, is_nobuf |-> nobuf_fields_ok, "bad no_buffers word")

  `GSP_ASSERT(a_ok_gen_nonzero, clk, rst_n, is_ok |-> ok_gen_good, "ok result with zero generation")

endmodule

bind generational_slot_pool gsp_checker u_gsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
